@@ hdl/assert_macros.svh @@
// assertion macros shared by the octave level design
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SROL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SROL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/srol_pkg.sv @@
// types and constants for the sliding range octave level block
// no dependencies
package srol_pkg;

	typedef enum logic [3:0] {
		F_IDLE,
		F_SCAN,
		F_OCT,
		F_DIV,
		F_POST1,
		F_POST2,
		F_POST3,
		F_POST4,
		F_POST5,
		F_PUSH
	} front_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam int WL_W = 9;
	localparam logic [WL_W-1:0] WINDOW_RESET = 9'd64;
	localparam int REG_W = 32;
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	// binary fractal odd factors and their thresholds in whole price units
	localparam int M_W = 12;
	localparam logic [M_W-1:0] FRAC_M5 = 12'd3125;
	localparam logic [M_W-1:0] FRAC_M4 = 12'd625;
	localparam logic [M_W-1:0] FRAC_M3 = 12'd125;
	localparam logic [M_W-1:0] FRAC_M2 = 12'd25;
	localparam int FRAC_T5 = 25000;
	localparam int FRAC_T4 = 2500;
	localparam int FRAC_T3 = 250;

	localparam int G_W = 5;
	localparam int GUARD = 5;

	localparam logic [3:0] LEVEL_FIRST = 4'd0;
	localparam logic [3:0] LEVEL_LAST = 4'd12;

endpackage

@@ hdl/srol_bar_if.sv @@
// bar input channel: valid/ready with high and low price
// depends on nothing
interface srol_bar_if #(parameter int PRICE_BITS = 40);
	logic                  valid;
	logic                  ready;
	logic [PRICE_BITS-1:0] high_price;
	logic [PRICE_BITS-1:0] low_price;

	modport source (output valid, output high_price, output low_price, input ready);
	modport sink (input valid, input high_price, input low_price, output ready);
endinterface

@@ hdl/srol_lvl_if.sv @@
// level output channel: valid/ready with level index, value and last flag
// depends on nothing
interface srol_lvl_if #(parameter int PRICE_BITS = 40);
	logic                       valid;
	logic                       ready;
	logic [3:0]                 level_index;
	logic signed [PRICE_BITS:0] level_value;
	logic                       last_level;

	modport source (output valid, output level_index, output level_value, output last_level,
		input ready);
	modport sink (input valid, input level_index, input level_value, input last_level,
		output ready);
endinterface

@@ hdl/srol_queue.sv @@
// two-entry queue between the front and the back
// uses srol_pkg
module srol_queue #(
	parameter int W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [W-1:0]      din,
	input  logic              pop,
	output logic [W-1:0]      dout,
	output srol_pkg::q_stat_t q_stat
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	assign dout         = mem_q[rd_q];
	assign q_stat.full  = cnt_q == 2'd2;
	assign q_stat.empty = cnt_q == 2'd0;

endmodule

@@ hdl/srol_front.sv @@
// front: bar history, window scan, octave search, serial divide, grid setup
// uses srol_pkg and srol_bar_if
module srol_front #(
	parameter int MAX_WINDOW    = 256,
	parameter int PRICE_BITS    = 40,
	parameter int FRACTION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	srol_bar_if.sink                       bar,
	input  logic [srol_pkg::WL_W-1:0]      window_length,
	input  srol_pkg::q_stat_t              q_stat,
	output logic                           push,
	output logic [PRICE_BITS+1:0]          mult_mi,
	output logic signed [PRICE_BITS+21:0]  base,
	output logic signed [PRICE_BITS+21:0]  step,
	output logic [srol_pkg::G_W-1:0]       frac_g
);

	localparam int P   = PRICE_BITS;
	localparam int WW  = P + 20;
	localparam int SW  = P + 22;
	localparam int XW  = P + 12;
	localparam int AW  = $clog2(MAX_WINDOW);
	localparam int BW  = $clog2(MAX_WINDOW + 2);
	localparam int CW  = (BW > srol_pkg::WL_W) ? BW : srol_pkg::WL_W;
	localparam int SHW = $clog2(P + 1);
	localparam int XCW = $clog2(XW + 1);
	localparam int MW  = srol_pkg::M_W;
	localparam int GW  = srol_pkg::G_W;

	srol_pkg::front_state_t state_q, state_nx;

	logic [P-1:0]  hi_mem [MAX_WINDOW];
	logic [P-1:0]  lo_mem [MAX_WINDOW];
	logic [P-1:0]  hi_rd_s1, lo_rd_s1;
	logic          rd_vld_s1;
	logic [AW-1:0] wp_q, ptr_q;
	logic [BW-1:0] bars_q, bars_nx;
	logic [CW-1:0] issue_q, len_q, win_len, wl_ext;

	logic [P-1:0]   v1_q, v2_q, range_q, rng_now, mi_q;
	logic [MW-1:0]  m_q, m_pick, rem_q, rem_out;
	logic           mode_q, mode_now, neg_q;
	logic [WW-1:0]  cmp_q;
	logic [SHW-1:0] cnt_q, sa_q;
	logic [XW-1:0]  x_q, quo_q, x_now;
	logic [XCW-1:0] dcnt_q;
	logic [MW:0]    rem_sh;
	logic           qbit;
	logic [WW-1:0]  mf_q, d1_q, rg_q, o_q, d2_q, r_q;
	logic [WW-1:0]  r3_q, r5_q, r7_q, r9_q, r13_q;
	logic [GW-1:0]  g_q, g_now;
	logic [SHW-1:0] e_now;
	logic [WW-1:0]  low_mask, d_pos, qm, u_now;
	logic [1:0]     n_q;
	logic [2:0]     hq_q, lq_q, dq;
	logic [P+1:0]   nmi_q;
	logic [WW-1:0]  nmf_q, lq8u_q, dqu_q;
	logic [WW-1:0]  thr5, thr4, thr3;
	logic           c1, c2, c3, c4, c5;
	logic           accept, hist_full, enough, scan_issue, scan_done, v_bad;
	logic           oct_step, div_done;

	assign accept    = bar.valid && bar.ready;
	assign hist_full = bars_q == BW'(MAX_WINDOW + 1);
	assign bars_nx   = hist_full ? bars_q : bars_q + BW'(1);
	assign wl_ext    = CW'(window_length);
	assign win_len   = (window_length == '0) ? CW'(1) :
		((wl_ext > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : wl_ext);
	assign enough     = CW'(bars_nx) > win_len;
	assign scan_issue = issue_q != len_q;
	assign scan_done  = !scan_issue && !rd_vld_s1;
	assign v_bad      = (v2_q == '0) || (v2_q <= v1_q);
	assign oct_step   = mode_q ? (cmp_q <= WW'(m_q)) : (cmp_q < WW'(range_q));
	assign div_done   = dcnt_q == '0;
	assign dq         = hq_q - lq_q;

	assign thr5 = WW'(srol_pkg::FRAC_T5) << FRACTION_BITS;
	assign thr4 = WW'(srol_pkg::FRAC_T4) << FRACTION_BITS;
	assign thr3 = WW'(srol_pkg::FRAC_T3) << FRACTION_BITS;
	always_comb begin
		if (WW'(v2_q) > thr5) m_pick = srol_pkg::FRAC_M5;
		else if (WW'(v2_q) > thr4) m_pick = srol_pkg::FRAC_M4;
		else if (WW'(v2_q) > thr3) m_pick = srol_pkg::FRAC_M3;
		else m_pick = srol_pkg::FRAC_M2;
	end
	assign rng_now  = v2_q - v1_q;
	assign mode_now = P'(m_pick) >= rng_now;

	assign x_now = (mode_q && cnt_q != '0) ? (XW'(v1_q) << cnt_q) : XW'(v1_q >> cnt_q);

	assign rem_sh  = {rem_q, quo_q[XW-1]};
	assign qbit    = rem_sh >= (MW+1)'(m_q);
	assign rem_out = qbit ? MW'(rem_sh - (MW+1)'(m_q)) : MW'(rem_sh);

	always_comb begin
		if (neg_q) begin
			g_now = GW'(srol_pkg::GUARD) + GW'(sa_q);
			e_now = SHW'(srol_pkg::GUARD);
		end else if (sa_q < SHW'(srol_pkg::GUARD)) begin
			g_now = GW'(SHW'(srol_pkg::GUARD) - sa_q);
			e_now = SHW'(srol_pkg::GUARD);
		end else begin
			g_now = '0;
			e_now = sa_q;
		end
	end
	assign low_mask = (WW'(1) << sa_q) - WW'(1);
	assign d_pos    = (WW'(rem_q) << sa_q) | (WW'(v1_q) & low_mask);
	assign qm       = WW'(x_q) - WW'(rem_q);
	assign u_now    = r_q >> 5;

	assign c2 = ((d1_q << 4) >= r3_q) && ((d2_q << 4) <= r9_q);
	assign c1 = ((d2_q << 3) <= r5_q) && !c2;
	assign c4 = ((d1_q << 4) >= r7_q) && ((d2_q << 4) <= r13_q);
	assign c5 = ((d1_q << 3) >= r3_q) && ((d2_q << 3) <= r9_q) && !c4;
	assign c3 = ((d1_q << 3) >= r_q) && ((d2_q << 3) <= r7_q) && !c1 && !c2 && !c4 && !c5;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			srol_pkg::F_IDLE:  if (accept && enough) state_nx = srol_pkg::F_SCAN;
			srol_pkg::F_SCAN:  if (scan_done) state_nx = v_bad ? srol_pkg::F_IDLE : srol_pkg::F_OCT;
			srol_pkg::F_OCT:   if (!oct_step) state_nx = srol_pkg::F_DIV;
			srol_pkg::F_DIV:   if (div_done) state_nx = srol_pkg::F_POST1;
			srol_pkg::F_POST1: state_nx = srol_pkg::F_POST2;
			srol_pkg::F_POST2: state_nx = srol_pkg::F_POST3;
			srol_pkg::F_POST3: state_nx = srol_pkg::F_POST4;
			srol_pkg::F_POST4: state_nx = srol_pkg::F_POST5;
			srol_pkg::F_POST5: state_nx = (dq == '0) ? srol_pkg::F_IDLE : srol_pkg::F_PUSH;
			srol_pkg::F_PUSH:  if (!q_stat.full) state_nx = srol_pkg::F_IDLE;
			default:           state_nx = srol_pkg::F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		bar.ready = state_q == srol_pkg::F_IDLE;
		push      = (state_q == srol_pkg::F_PUSH) && !q_stat.full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= srol_pkg::F_IDLE;
			wp_q      <= '0;
			bars_q    <= '0;
			ptr_q     <= '0;
			issue_q   <= '0;
			len_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_nx;
			rd_vld_s1 <= (state_q == srol_pkg::F_SCAN) && scan_issue;
			if (accept) begin
				wp_q    <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
				bars_q  <= bars_nx;
				ptr_q   <= wp_q;
				issue_q <= '0;
				len_q   <= win_len;
			end else if (state_q == srol_pkg::F_SCAN && scan_issue) begin
				issue_q <= issue_q + CW'(1);
				ptr_q   <= (ptr_q == '0) ? AW'(MAX_WINDOW - 1) : ptr_q - AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hi_mem[wp_q] <= bar.high_price;
			lo_mem[wp_q] <= bar.low_price;
		end
		hi_rd_s1 <= hi_mem[ptr_q];
		lo_rd_s1 <= lo_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			srol_pkg::F_IDLE: begin
				if (accept) begin
					v1_q <= bar.low_price;
					v2_q <= bar.high_price;
				end
			end
			srol_pkg::F_SCAN: begin
				if (rd_vld_s1) begin
					if (lo_rd_s1 < v1_q) v1_q <= lo_rd_s1;
					if (hi_rd_s1 > v2_q) v2_q <= hi_rd_s1;
				end
				range_q <= rng_now;
				m_q     <= m_pick;
				mode_q  <= mode_now;
				cmp_q   <= mode_now ? (WW'(rng_now) << 1) : (WW'(m_pick) << 1);
				cnt_q   <= mode_now ? SHW'(0) : SHW'(1);
			end
			srol_pkg::F_OCT: begin
				if (oct_step) begin
					cnt_q <= cnt_q + SHW'(1);
					cmp_q <= cmp_q << 1;
				end else begin
					neg_q  <= mode_q && cnt_q != '0;
					sa_q   <= cnt_q;
					x_q    <= x_now;
					quo_q  <= x_now;
					rem_q  <= '0;
					dcnt_q <= XCW'(XW);
				end
			end
			srol_pkg::F_DIV: begin
				if (!div_done) begin
					rem_q  <= rem_out;
					quo_q  <= {quo_q[XW-2:0], qbit};
					dcnt_q <= dcnt_q - XCW'(1);
				end
			end
			srol_pkg::F_POST1: begin
				g_q  <= g_now;
				rg_q <= WW'(range_q) << g_now;
				o_q  <= WW'(m_q) << e_now;
				if (neg_q) begin
					d1_q <= WW'(rem_q) << srol_pkg::GUARD;
					mi_q <= P'(qm >> sa_q);
					mf_q <= (qm & low_mask) << srol_pkg::GUARD;
				end else begin
					d1_q <= d_pos << g_now;
					mi_q <= v1_q - P'(d_pos);
					mf_q <= '0;
				end
			end
			srol_pkg::F_POST2: begin
				d2_q <= d1_q + rg_q;
				r_q  <= (o_q > d1_q + rg_q) ? o_q : (o_q << 1);
			end
			srol_pkg::F_POST3: begin
				r3_q  <= r_q + (r_q << 1);
				r5_q  <= r_q + (r_q << 2);
				r7_q  <= (r_q << 3) - r_q;
				r9_q  <= (r_q << 3) + r_q;
				r13_q <= (r_q << 3) + (r_q << 2) + r_q;
			end
			srol_pkg::F_POST4: begin
				if (!c1 && !c2 && !c3 && !c4 && !c5) begin
					n_q  <= 2'd1;
					hq_q <= 3'd4;
					lq_q <= 3'd0;
				end else begin
					n_q  <= 2'(c1) + 2'(c2) + 2'(c3) + 2'(c4) + 2'(c5);
					hq_q <= (c1 ? 3'd2 : 3'd0) + (c2 ? 3'd2 : 3'd0) + (c3 ? 3'd3 : 3'd0)
						+ (c4 ? 3'd3 : 3'd0) + (c5 ? 3'd4 : 3'd0);
					lq_q <= (c2 ? 3'd1 : 3'd0) + (c3 ? 3'd1 : 3'd0) + (c4 ? 3'd2 : 3'd0)
						+ (c5 ? 3'd2 : 3'd0);
				end
			end
			srol_pkg::F_POST5: begin
				nmi_q  <= (n_q[0] ? (P+2)'(mi_q) : '0) + (n_q[1] ? ((P+2)'(mi_q) << 1) : '0);
				nmf_q  <= (n_q[0] ? mf_q : '0) + (n_q[1] ? (mf_q << 1) : '0);
				lq8u_q <= ((lq_q[0] ? u_now : '0) + (lq_q[1] ? (u_now << 1) : '0)
					+ (lq_q[2] ? (u_now << 2) : '0)) << 3;
				dqu_q  <= (dq[0] ? u_now : '0) + (dq[1] ? (u_now << 1) : '0)
					+ (dq[2] ? (u_now << 2) : '0);
			end
			default: begin
			end
		endcase
	end

	assign mult_mi = nmi_q;
	assign base    = SW'(nmf_q) + SW'(lq8u_q) - (SW'(dqu_q) << 1);
	assign step    = SW'(dqu_q);
	assign frac_g  = g_q;

endmodule

@@ hdl/srol_back.sv @@
// back: walks the 13 grid levels of one queued bar and rounds each to the price grid
// uses srol_pkg and srol_lvl_if
module srol_back #(
	parameter int PRICE_BITS = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srol_pkg::q_stat_t             q_stat,
	output logic                          pop,
	input  logic [PRICE_BITS+1:0]         head_mi,
	input  logic signed [PRICE_BITS+21:0] head_base,
	input  logic signed [PRICE_BITS+21:0] head_step,
	input  logic [srol_pkg::G_W-1:0]      head_g,
	srol_lvl_if.source                    lvl
);

	localparam int P  = PRICE_BITS;
	localparam int SW = P + 22;
	localparam int GW = srol_pkg::G_W;
	localparam logic signed [SW-1:0] LV_MAX = {{(SW-P){1'b0}}, {P{1'b1}}};
	localparam logic signed [SW-1:0] LV_MIN = {{(SW-P){1'b1}}, {P{1'b0}}};

	logic                 busy_q, out_vld_q, out_last_q, emit;
	logic [3:0]           idx_q, out_idx_q;
	logic signed [SW-1:0] w_q, step_q, half, rnd, tot, sat;
	logic [P+1:0]         a_q;
	logic [GW-1:0]        g_q;
	logic signed [P:0]    out_val_q;

	assign pop  = !busy_q && !q_stat.empty;
	assign emit = busy_q && (!out_vld_q || lvl.ready);

	// round half up: add half an lsb then floor
	assign half = (g_q == '0) ? '0 : (SW'(1) << (g_q - GW'(1)));
	assign rnd  = (w_q + half) >>> g_q;
	assign tot  = rnd + $signed(SW'(a_q));
	assign sat  = (tot > LV_MAX) ? LV_MAX : ((tot < LV_MIN) ? LV_MIN : tot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_vld_q <= 1'b0;
			idx_q     <= srol_pkg::LEVEL_FIRST;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= srol_pkg::LEVEL_FIRST;
			end else if (emit) begin
				idx_q <= idx_q + 4'd1;
				if (idx_q == srol_pkg::LEVEL_LAST) busy_q <= 1'b0;
			end
			if (emit) out_vld_q <= 1'b1;
			else if (lvl.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			a_q    <= head_mi;
			w_q    <= head_base;
			step_q <= head_step;
			g_q    <= head_g;
		end else if (emit) begin
			w_q <= w_q + step_q;
		end
		if (emit) begin
			out_idx_q  <= idx_q;
			out_val_q  <= sat[P:0];
			out_last_q <= idx_q == srol_pkg::LEVEL_LAST;
		end
	end

	assign lvl.valid       = out_vld_q;
	assign lvl.level_index = out_idx_q;
	assign lvl.level_value = out_val_q;
	assign lvl.last_level  = out_last_q;

endmodule

@@ hdl/sliding_range_octave_levels.sv @@
// top level of the sliding range octave level block: config register, front, queue, back
// uses srol_pkg, srol_bar_if, srol_lvl_if, srol_front, srol_queue, srol_back, assert_macros.svh
//
// Takes one bar (high, low) per word and, once more than window_length bars are held,
// emits 13 Murrey octave levels (-2/8 .. +2/8) for the window, last one flagged. A bar
// that yields levels keeps the front busy through the window scan, one history entry
// per cycle from the history memory (window_length, clamped to 1..MAX_WINDOW), the
// octave search (one shift per cycle), a one-bit-per-cycle divider over PRICE_BITS + 12
// quotient bits, the grid setup steps and the push, which waits while the queue is full.
// A bar that yields nothing leaves the input ready (short history), or frees it after
// the scan or after the grid setup. The back emits one level per cycle while the level
// channel is ready, from a two-entry queue, so it overlaps the front's work on the next bar.
`include "assert_macros.svh"

module sliding_range_octave_levels #(
	parameter int MAX_WINDOW    = 256,
	parameter int PRICE_BITS    = 40,
	parameter int FRACTION_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [srol_pkg::REG_W-1:0]  pwdata,
	output logic [srol_pkg::REG_W-1:0]  prdata,
	output logic                        pready,
	srol_bar_if.sink                    bar,
	srol_lvl_if.source                  lvl
);

	localparam int SW = PRICE_BITS + 22;
	localparam int GW = srol_pkg::G_W;
	localparam int QW = (PRICE_BITS + 2) + SW + SW + GW;

	logic [srol_pkg::WL_W-1:0] window_length_q;
	srol_pkg::q_stat_t         q_stat;
	logic                      push, pop;
	logic [PRICE_BITS+1:0]     f_mi, b_mi;
	logic signed [SW-1:0]      f_base, f_step, b_base, b_step;
	logic [GW-1:0]             f_g, b_g;
	logic [QW-1:0]             q_in, q_out;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == srol_pkg::REG_WINDOW_LENGTH) ?
		srol_pkg::REG_W'(window_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= srol_pkg::WINDOW_RESET;
		end else if (psel && penable && pwrite && paddr[2] == srol_pkg::REG_WINDOW_LENGTH) begin
			window_length_q <= pwdata[srol_pkg::WL_W-1:0];
		end
	end

	srol_front #(
		.MAX_WINDOW    (MAX_WINDOW),
		.PRICE_BITS    (PRICE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.bar           (bar),
		.window_length (window_length_q),
		.q_stat        (q_stat),
		.push          (push),
		.mult_mi       (f_mi),
		.base          (f_base),
		.step          (f_step),
		.frac_g        (f_g)
	);

	assign q_in = {f_mi, f_base, f_step, f_g};

	srol_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_in),
		.pop    (pop),
		.dout   (q_out),
		.q_stat (q_stat)
	);

	assign {b_mi, b_base, b_step, b_g} = q_out;

	srol_back #(.PRICE_BITS(PRICE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop       (pop),
		.head_mi   (b_mi),
		.head_base (b_base),
		.head_step (b_step),
		.head_g    (b_g),
		.lvl       (lvl)
	);

	`SROL_ASSERT_IMP(a_no_overflow, q_stat.full, !push, "queue write while full")
	`SROL_ASSERT_NXT(a_push_lands, push, !q_stat.empty, "queued word went missing")
	`SROL_ASSERT_IMP(a_last_is_top, lvl.valid && lvl.last_level, lvl.level_index == srol_pkg::LEVEL_LAST, "last flag on wrong level")
	`SROL_ASSERT_IMP(a_index_range, lvl.valid, lvl.level_index <= srol_pkg::LEVEL_LAST, "level index out of range")

endmodule

@@ tb/tb_top.sv @@
// self-checking bench for sliding_range_octave_levels: random bars with stalls on both channels
// depends on srol_pkg, srol_bar_if, srol_lvl_if and the block under test
// a built-in octave grid predictor supplies the expected level words
module tb_top;

	localparam int PB = 40;
	localparam int FB = 16;
	localparam int HIST = 256;
	localparam longint unsigned PMAX = (64'd1 << PB) - 1;
	localparam int SETTLE = 420;

	typedef struct {
		logic [PB-1:0] hi;
		logic [PB-1:0] lo;
	} bar_word_t;

	typedef struct {
		logic [3:0]           idx;
		logic signed [PB:0]   val;
		logic                 last;
	} level_word_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [srol_pkg::REG_W-1:0] pwdata, prdata;
	logic pready;

	srol_bar_if #(.PRICE_BITS(PB)) bar_ch ();
	srol_lvl_if #(.PRICE_BITS(PB)) lvl_ch ();

	sliding_range_octave_levels #(.MAX_WINDOW(HIST), .PRICE_BITS(PB), .FRACTION_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.bar(bar_ch.sink), .lvl(lvl_ch.source)
	);

	bar_word_t bar_pending_q[$];
	level_word_t level_expect_q[$];

	longint unsigned high_hist[HIST];
	longint unsigned low_hist[HIST];
	int unsigned wr_pos;
	int unsigned bars_held;
	int unsigned window_len;

	int mismatches;
	bit calm;
	bit bar_took;
	int src_gap, snk_gap;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned pick_m(longint unsigned v2);
		if (v2 > (64'd25000 << FB)) return 3125;
		else if (v2 > (64'd2500 << FB)) return 625;
		else if (v2 > (64'd250 << FB)) return 125;
		return 25;
	endfunction

	function automatic void octave_levels_predict(longint unsigned hi, longint unsigned lo);
		longint unsigned v1, v2, range, m, q, d1, d2, rg, oct, r, u, mi, mf, oc, nn, qm;
		int unsigned len, idx, e, g, t, ns;
		int s;
		bit c1, c2, c3, c4, c5;
		longint n, lq, hq, dq, w, tot;
		level_word_t lw;
		high_hist[wr_pos] = hi;
		low_hist[wr_pos] = lo;
		wr_pos = (wr_pos + 1) % HIST;
		if (bars_held < HIST + 1) bars_held++;
		len = window_len;
		if (len < 1) len = 1;
		if (len > HIST) len = HIST;
		if (bars_held <= len) return;
		v1 = lo;
		v2 = hi;
		idx = wr_pos;
		for (int k = 0; k < len; k++) begin
			idx = (idx + HIST - 1) % HIST;
			if (low_hist[idx] < v1) v1 = low_hist[idx];
			if (high_hist[idx] > v2) v2 = high_hist[idx];
		end
		if (v2 == 0 || v2 <= v1) return;
		m = pick_m(v2);
		range = v2 - v1;
		if (m >= range) begin
			t = 0;
			while ((range << (t + 1)) <= m) t++;
			s = -int'(t);
		end else begin
			s = 1;
			while ((m << s) < range) s++;
		end
		e = (s > 5) ? s : 5;
		g = e - s;
		oct = m << e;
		if (s >= 0) begin
			oc = m << s;
			q = v1 / oc;
			mi = q * oc;
			d1 = (v1 - mi) << g;
			mf = 0;
		end else begin
			ns = -s;
			nn = v1 << ns;
			q = nn / m;
			qm = q * m;
			d1 = (nn - qm) << 5;
			mi = qm >> ns;
			mf = (qm & ((64'd1 << ns) - 1)) << 5;
		end
		rg = range << g;
		d2 = d1 + rg;
		r = (oct > d2) ? oct : 2 * oct;
		c2 = (16 * d1 >= 3 * r) && (16 * d2 <= 9 * r);
		c1 = (8 * d2 <= 5 * r) && !c2;
		c4 = (16 * d1 >= 7 * r) && (16 * d2 <= 13 * r);
		c5 = (8 * d1 >= 3 * r) && (8 * d2 <= 9 * r) && !c4;
		c3 = (8 * d1 >= r) && (8 * d2 <= 7 * r) && !c1 && !c2 && !c4 && !c5;
		n = 0;
		lq = 0;
		hq = 0;
		if (c1) begin n++; hq += 2; end
		if (c2) begin n++; hq += 2; lq += 1; end
		if (c3) begin n++; hq += 3; lq += 1; end
		if (c4) begin n++; hq += 3; lq += 2; end
		if (c5) begin n++; hq += 4; lq += 2; end
		if (n == 0) begin
			n = 1;
			hq = 4;
		end
		dq = hq - lq;
		if (dq == 0) return;
		u = r / 32;
		for (int i = 0; i < 13; i++) begin
			w = n * longint'(mf) + lq * 8 * longint'(u) + longint'(i - 2) * dq * longint'(u);
			// round half up to the price grid
			if (g > 0) w = (w + (longint'(1) << (g - 1))) >>> g;
			tot = n * longint'(mi) + w;
			if (tot > longint'(PMAX)) tot = longint'(PMAX);
			if (tot < -longint'(PMAX) - 1) tot = -longint'(PMAX) - 1;
			lw.idx = 4'(i);
			lw.val = tot[PB:0];
			lw.last = (i == 12);
			level_expect_q.push_back(lw);
		end
	endfunction

	// bar driver
	always @(negedge clk) begin
		if (!arst_n) begin
			bar_ch.valid <= 1'b0;
		end else if (bar_took || !bar_ch.valid) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				bar_ch.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				src_gap <= $urandom_range(0, 13);
				bar_ch.valid <= 1'b0;
			end else if (bar_pending_q.size() > 0) begin
				bar_ch.valid <= 1'b1;
				bar_ch.high_price <= bar_pending_q[0].hi;
				bar_ch.low_price <= bar_pending_q[0].lo;
				bar_pending_q.pop_front();
			end else begin
				bar_ch.valid <= 1'b0;
			end
		end
	end

	// level sink stalls
	always @(negedge clk) begin
		if (calm) begin
			lvl_ch.ready <= 1'b1;
		end else if (snk_gap > 0) begin
			snk_gap <= snk_gap - 1;
			lvl_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 11) == 0) begin
			snk_gap <= $urandom_range(0, 13);
			lvl_ch.ready <= 1'b0;
		end else begin
			lvl_ch.ready <= 1'b1;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		level_word_t exp_w;
		bar_took <= arst_n && bar_ch.valid && bar_ch.ready;
		if (arst_n && bar_ch.valid && bar_ch.ready)
			octave_levels_predict(bar_ch.high_price, bar_ch.low_price);
		if (arst_n && lvl_ch.valid && lvl_ch.ready) begin
			if (level_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected level word idx=%0d val=%0d last=%0b",
						lvl_ch.level_index, lvl_ch.level_value, lvl_ch.last_level);
			end else begin
				exp_w = level_expect_q.pop_front();
				if (lvl_ch.level_index !== exp_w.idx || lvl_ch.level_value !== exp_w.val ||
					lvl_ch.last_level !== exp_w.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("level mismatch exp idx=%0d val=%0d last=%0b got idx=%0d val=%0d last=%0b",
							exp_w.idx, exp_w.val, exp_w.last, lvl_ch.level_index,
							lvl_ch.level_value, lvl_ch.last_level);
				end
			end
		end
	end

	task automatic reg_write(input logic [srol_pkg::REG_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {srol_pkg::REG_WINDOW_LENGTH, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		window_len = value & 32'h1FF;
	endtask

	task automatic drain();
		while (bar_pending_q.size() > 0 || bar_ch.valid || level_expect_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_bar(input longint unsigned hi, input longint unsigned lo);
		bar_word_t b;
		b.hi = hi;
		b.lo = lo;
		bar_pending_q.push_back(b);
	endtask

	task automatic push_random(input int count, input int scale);
		longint unsigned center, spread, hi, lo, mask;
		mask = (scale >= PB) ? PMAX : ((64'd1 << scale) - 1);
		center = {$urandom, $urandom} & mask;
		for (int i = 0; i < count; i++) begin
			spread = {$urandom, $urandom} & (mask >> $urandom_range(0, 6));
			case ($urandom_range(0, 19))
				0: begin hi = {$urandom, $urandom} & PMAX; lo = {$urandom, $urandom} & PMAX; end
				1: begin hi = PMAX; lo = 0; end
				2: begin hi = 0; lo = {$urandom, $urandom} & mask; end
				default: begin
					hi = center + ({$urandom, $urandom} % (spread + 1));
					lo = (center > spread) ? center - ({$urandom, $urandom} % (spread + 1)) : 0;
					if (hi > PMAX) hi = PMAX;
					if ($urandom_range(0, 3) == 0)
						center = (center + ({$urandom, $urandom} & (mask >> 3))) & mask;
				end
			endcase
			push_bar(hi, lo);
		end
	endtask

	initial begin
		int windows[8];
		int counts[8];
		longint unsigned th;
		windows = '{1, 0, 3, 511, 17, 256, 64, 2};
		counts = '{60, 40, 50, 50, 50, 70, 50, 50};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		bar_ch.valid = 1'b0;
		bar_ch.high_price = '0;
		bar_ch.low_price = '0;
		lvl_ch.ready = 1'b0;
		calm = 1'b0;
		bar_took = 1'b0;
		src_gap = 0;
		snk_gap = 0;
		mismatches = 0;
		wr_pos = 0;
		bars_held = 0;
		window_len = srol_pkg::WINDOW_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single-bar window across extremes and fractal thresholds
		reg_write(1);
		push_bar(PMAX, 0);
		push_bar(PMAX, 0);
		push_bar(PMAX, PMAX);
		push_bar(0, 0);
		push_bar(5, 7);
		push_bar(1, 0);
		push_bar(PMAX, PMAX - 1);
		foreach (windows[j]) begin
			th = (j == 0) ? (64'd25000 << FB) : (j == 1) ? (64'd2500 << FB) :
				(j == 2) ? (64'd250 << FB) : (j == 3) ? (64'd25 << FB) :
				(j == 4) ? (64'd25 << (FB - 1)) : (j == 5) ? (64'd25 << (FB - 2)) :
				(j == 6) ? (64'd25 << (FB - 3)) : (64'd25 << (FB - 6));
			push_bar(th + 1, th / 2);
			push_bar(th, th - 3);
		end
		drain();

		foreach (windows[j]) begin
			reg_write(windows[j]);
			if (j == 7) begin
				push_random(counts[j] - 30, $urandom_range(6, PB));
				drain();
				calm = 1'b1;
				push_random(30, $urandom_range(6, PB));
			end else begin
				push_random(counts[j], (j % 2) ? $urandom_range(6, 24) : $urandom_range(20, PB));
			end
			drain();
		end

		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#20000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
